@@ sv/rvex_pkg.sv @@
package rvex_pkg;

	localparam logic [6:0] OP_LOAD  = 7'b0000011;
	localparam logic [6:0] OP_ALUI  = 7'b0010011;
	localparam logic [6:0] OP_STORE = 7'b0100011;
	localparam logic [6:0] OP_ALUR  = 7'b0110011;

	localparam logic [6:0] F7_ZERO = 7'b0000000;
	localparam logic [6:0] F7_ALT  = 7'b0100000;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;

	localparam logic [2:0] F3_SB = 3'd0;
	localparam logic [2:0] F3_SH = 3'd1;
	localparam logic [2:0] F3_SW = 3'd2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNSUP    = 2'd1,
		ST_MISALIGN = 2'd2
	} status_t;

	typedef struct packed {
		logic [4:0]  rd;
		logic        wr;
		logic [31:0] value;
		logic [31:0] addr;
		status_t     status;
		logic        load;
		logic        store;
		logic [2:0]  f3;
		logic [3:0]  be;
		logic [31:0] wdata;
	} exec_t;

	typedef struct packed {
		logic        en;
		logic [4:0]  addr;
		logic [31:0] data;
	} wb_t;

	function automatic logic [31:0] load_format(input logic [31:0] word,
			input logic [2:0] f3, input logic [1:0] off);
		logic [31:0] sh;
		logic [31:0] res;
		sh = word >> {off, 3'b000};
		unique case (f3)
			F3_LB:   res = {{24{sh[7]}}, sh[7:0]};
			F3_LBU:  res = {24'd0, sh[7:0]};
			F3_LH:   res = {{16{sh[15]}}, sh[15:0]};
			F3_LHU:  res = {16'd0, sh[15:0]};
			default: res = sh;
		endcase
		return res;
	endfunction

endpackage

@@ sv/rv32i_alu_load_store_execute.sv @@
// rv32i integer execute unit: alu ops, loads and stores
//
// input channel: instruction with instruction_valid / instruction_stall; one
// item is one 32-bit rv32i instruction word
// output channel: dest_reg, dest_value, dest_written, access_address, status
// with result_valid / result_stall; exactly one result item per instruction,
// in order
//
// stages: register file read at the accepting edge, execute with data memory access,
// then load alignment and write back into the output register
// throughput: one item per cycle unless stalled; an instruction that needs the load
// directly ahead of it waits for the data memory read while that load is in s2
// register file and data memory are synchronous memories with a registered read;
// results still in flight are forwarded to the execute stage
//
// reset: register file reads as zero everywhere through per-entry valid bits,
// data memory contents are undefined until written; no clearing pass
// while result_stall is high the result is held, the pipeline behind it
// keeps filling and instruction_stall rises once all stages are full
module rv32i_alu_load_store_execute import rvex_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instruction_valid,
	output logic        instruction_stall,
	input  logic [31:0] instruction,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [4:0]  dest_reg,
	output logic [31:0] dest_value,
	output logic        dest_written,
	output logic [15:0] access_address,
	output logic [1:0]  status
);

	localparam int WORD_BITS = ADDR_BITS - 2;

	logic        in_acc;
	logic        valid_s1;
	logic [31:0] inst_s1;
	logic        valid_s2;
	exec_t       ex_s2;
	exec_t       ex;
	logic        out_valid_q;
	logic [4:0]  dest_reg_q;
	logic [31:0] dest_value_q;
	logic        dest_written_q;
	logic [15:0] access_address_q;
	status_t     status_q;

	logic        out_free;
	logic        s2_move;
	logic        s2_free;
	logic        s1_move;
	logic        s1_free;
	logic        hazard;

	logic [31:0] rf_a;
	logic [31:0] rf_b;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic        ovr_a_q;
	logic        ovr_b_q;
	logic [31:0] ovr_a_val_q;
	logic [31:0] ovr_b_val_q;
	logic        fwd_a;
	logic        fwd_b;
	logic [4:0]  rs1_s1;
	logic [4:0]  rs2_s1;

	logic [31:0] mem_rdata;
	logic [31:0] final_val;
	logic        mem_rd;
	logic        mem_wr;
	wb_t         wb;

	assign rs1_s1 = inst_s1[19:15];
	assign rs2_s1 = inst_s1[24:20];

	// handshake and stage advance
	assign out_free = !out_valid_q || !result_stall;
	assign s2_move  = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || s2_move;
	assign hazard   = valid_s2 && ex_s2.load && (ex_s2.rd == rs1_s1 || ex_s2.rd == rs2_s1);
	assign s1_move  = valid_s1 && !hazard && s2_free;
	assign s1_free  = !valid_s1 || s1_move;
	assign in_acc   = instruction_valid && s1_free;
	assign instruction_stall = !s1_free;

	// write back
	assign final_val = ex_s2.load ? load_format(mem_rdata, ex_s2.f3, ex_s2.addr[1:0])
	                              : ex_s2.value;
	assign wb.en   = s2_move && ex_s2.wr;
	assign wb.addr = ex_s2.rd;
	assign wb.data = final_val;

	rvex_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rs1     (instruction[19:15]),
		.rs2     (instruction[24:20]),
		.wb      (wb),
		.rdata_a (rf_a),
		.rdata_b (rf_b)
	);

	// operand forwarding: alu result in s2, else latest write back since the read
	assign fwd_a = valid_s2 && ex_s2.wr && !ex_s2.load && ex_s2.rd == rs1_s1;
	assign fwd_b = valid_s2 && ex_s2.wr && !ex_s2.load && ex_s2.rd == rs2_s1;
	assign op_a  = fwd_a ? ex_s2.value : (ovr_a_q ? ovr_a_val_q : rf_a);
	assign op_b  = fwd_b ? ex_s2.value : (ovr_b_q ? ovr_b_val_q : rf_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovr_a_q <= 1'b0;
			ovr_b_q <= 1'b0;
		end else if (in_acc) begin
			ovr_a_q     <= wb.en && wb.addr == instruction[19:15];
			ovr_b_q     <= wb.en && wb.addr == instruction[24:20];
			ovr_a_val_q <= wb.data;
			ovr_b_val_q <= wb.data;
		end else if (valid_s1) begin
			if (wb.en && wb.addr == rs1_s1) begin
				ovr_a_q     <= 1'b1;
				ovr_a_val_q <= wb.data;
			end
			if (wb.en && wb.addr == rs2_s1) begin
				ovr_b_q     <= 1'b1;
				ovr_b_val_q <= wb.data;
			end
		end
	end

	rvex_exec #(
		.ADDR_BITS (ADDR_BITS)
	) u_exec (
		.inst (inst_s1),
		.a    (op_a),
		.b    (op_b),
		.ex   (ex)
	);

	assign mem_rd = s1_move && ex.load;
	assign mem_wr = s1_move && ex.store;

	rvex_dmem #(
		.WORD_BITS (WORD_BITS)
	) u_dmem (
		.clk   (clk),
		.rd_en (mem_rd),
		.wr_en (mem_wr),
		.addr  (ex.addr[ADDR_BITS-1:2]),
		.be    (ex.be),
		.wdata (ex.wdata),
		.rdata (mem_rdata)
	);

	// pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= instruction_valid;
			end
			if (s2_free) begin
				valid_s2 <= s1_move;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			inst_s1 <= instruction;
		end
		if (s1_move) begin
			ex_s2 <= ex;
		end
		if (s2_move) begin
			dest_reg_q       <= ex_s2.rd;
			dest_value_q     <= ex_s2.wr ? final_val : 32'd0;
			dest_written_q   <= ex_s2.wr;
			access_address_q <= ex_s2.addr[15:0];
			status_q         <= ex_s2.status;
		end
	end

	assign result_valid   = out_valid_q;
	assign dest_reg       = dest_reg_q;
	assign dest_value     = dest_value_q;
	assign dest_written   = dest_written_q;
	assign access_address = access_address_q;
	assign status         = status_q;

	// checks
	a_written_rd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && dest_written |-> dest_reg != 5'd0)
		else $error("register write reported for x0");

	a_unwritten_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !dest_written |-> dest_value == 32'd0)
		else $error("nonzero value without register write");

	a_unsup_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status_q == ST_UNSUP |-> !dest_written && access_address == 16'd0)
		else $error("unsupported item changed state");

	a_mem_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_rd && mem_wr))
		else $error("data memory read and write in one cycle");

	a_load_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		hazard |=> !valid_s2 || !ex_s2.load || $past(!s2_move))
		else $error("load dependency not resolved");

endmodule

@@ sv/rvex_regfile.sv @@
module rvex_regfile import rvex_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd_en,
	input  logic [4:0]  rs1,
	input  logic [4:0]  rs2,
	input  wb_t         wb,
	output logic [31:0] rdata_a,
	output logic [31:0] rdata_b
);

	logic [31:0] rf [32];
	logic [31:0] valid_q;
	logic [31:0] data_a_q;
	logic [31:0] data_b_q;
	logic        vld_a_q;
	logic        vld_b_q;

	always_ff @(posedge clk) begin
		if (wb.en) begin
			rf[wb.addr] <= wb.data;
		end
		if (rd_en) begin
			data_a_q <= rf[rs1];
			data_b_q <= rf[rs2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (wb.en) begin
				valid_q[wb.addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_q <= valid_q[rs1];
				vld_b_q <= valid_q[rs2];
			end
		end
	end

	assign rdata_a = vld_a_q ? data_a_q : 32'd0;
	assign rdata_b = vld_b_q ? data_b_q : 32'd0;

endmodule

@@ sv/rvex_exec.sv @@
module rvex_exec import rvex_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  logic [31:0] inst,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output exec_t       ex
);

	localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);

	logic [6:0]  opc;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] opb;
	logic [31:0] res;
	logic [31:0] addr;
	logic        is_reg;
	logic        f7_zero;
	logic        f7_alt;
	logic        ok;
	logic        misal;

	always_comb begin
		opc     = inst[6:0];
		rd      = inst[11:7];
		f3      = inst[14:12];
		f7      = inst[31:25];
		imm_i   = {{20{inst[31]}}, inst[31:20]};
		imm_s   = {{20{inst[31]}}, inst[31:25], inst[11:7]};
		is_reg  = (opc == OP_ALUR);
		f7_zero = (f7 == F7_ZERO);
		f7_alt  = (f7 == F7_ALT);
		opb     = is_reg ? b : ((f3 == F3_SLL || f3 == F3_SR) ? {27'd0, inst[24:20]} : imm_i);
		res     = 32'd0;
		ok      = 1'b0;
		addr    = 32'd0;
		misal   = 1'b0;
		ex      = '0;
		ex.status = ST_OK;

		unique case (f3)
			F3_ADD: begin
				if (is_reg && f7_alt) begin
					res = a - opb;
					ok  = 1'b1;
				end else if (!is_reg || f7_zero) begin
					res = a + opb;
					ok  = 1'b1;
				end
			end
			F3_SLL: begin
				res = a << opb[4:0];
				ok  = f7_zero;
			end
			F3_SLT: begin
				res = {31'd0, $signed(a) < $signed(opb)};
				ok  = !is_reg || f7_zero;
			end
			F3_SLTU: begin
				res = {31'd0, a < opb};
				ok  = !is_reg || f7_zero;
			end
			F3_XOR: begin
				res = a ^ opb;
				ok  = !is_reg || f7_zero;
			end
			F3_SR: begin
				res = f7_alt ? 32'($signed(a) >>> opb[4:0]) : (a >> opb[4:0]);
				ok  = f7_zero || f7_alt;
			end
			F3_OR: begin
				res = a | opb;
				ok  = !is_reg || f7_zero;
			end
			F3_AND: begin
				res = a & opb;
				ok  = !is_reg || f7_zero;
			end
			default: begin
				res = 32'd0;
				ok  = 1'b0;
			end
		endcase

		priority if (opc == OP_ALUR || opc == OP_ALUI) begin
			if (ok) begin
				ex.rd    = rd;
				ex.wr    = (rd != 5'd0);
				ex.value = (rd != 5'd0) ? res : 32'd0;
			end else begin
				ex.status = ST_UNSUP;
			end
		end else if (opc == OP_LOAD) begin
			if (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU || f3 == F3_LHU) begin
				addr  = (a + imm_i) & ADDR_MASK;
				misal = (f3[1:0] == 2'b01 && addr[0]) || (f3 == F3_LW && addr[1:0] != 2'b00);
				ex.rd      = rd;
				ex.wr      = (rd != 5'd0);
				ex.addr    = addr;
				ex.f3      = f3;
				ex.load    = !misal && (rd != 5'd0);
				ex.status  = misal ? ST_MISALIGN : ST_OK;
			end else begin
				ex.status = ST_UNSUP;
			end
		end else if (opc == OP_STORE) begin
			if (f3 == F3_SB || f3 == F3_SH || f3 == F3_SW) begin
				addr  = (a + imm_s) & ADDR_MASK;
				misal = (f3 == F3_SH && addr[0]) || (f3 == F3_SW && addr[1:0] != 2'b00);
				ex.addr   = addr;
				ex.f3     = f3;
				ex.store  = !misal;
				ex.status = misal ? ST_MISALIGN : ST_OK;
				if (f3 == F3_SB) begin
					ex.be    = 4'b0001 << addr[1:0];
					ex.wdata = {4{b[7:0]}};
				end else if (f3 == F3_SH) begin
					ex.be    = 4'b0011 << addr[1:0];
					ex.wdata = {2{b[15:0]}};
				end else begin
					ex.be    = 4'b1111;
					ex.wdata = b;
				end
			end else begin
				ex.status = ST_UNSUP;
			end
		end else begin
			ex.status = ST_UNSUP;
		end
	end

endmodule

@@ sv/rvex_dmem.sv @@
module rvex_dmem #(
	parameter int WORD_BITS = 14
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic                 wr_en,
	input  logic [WORD_BITS-1:0] addr,
	input  logic [3:0]           be,
	input  logic [31:0]          wdata,
	output logic [31:0]          rdata
);

	localparam longint DEPTH = 64'd1 << WORD_BITS;

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < 4; i++) begin
				if (be[i]) begin
					mem[addr][8*i +: 8] <= wdata[8*i +: 8];
				end
			end
		end
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ test/rv32i_execute_checker.sv @@
module rv32i_execute_checker import rvex_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instruction_valid,
	input  logic        instruction_stall,
	input  logic [31:0] instruction,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [4:0]  dest_reg,
	input  logic [31:0] dest_value,
	input  logic        dest_written,
	input  logic [15:0] access_address,
	input  logic [1:0]  status,
	output int          errors,
	output int          pending,
	output int          checked,
	output int          loads,
	output int          stores,
	output int          misaligned,
	output int          unsupported
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [4:0]  rd;
		logic [31:0] value;
		logic        wr;
		logic [15:0] addr;
		status_t     st;
	} retire_t;

	retire_t     retire_q[$];
	logic [31:0] gpr [32];
	logic [7:0]  dmem [0:65535];

	task automatic execute(input logic [31:0] w, output retire_t r);
		logic [6:0]  opc, f7;
		logic [4:0]  rd, rs1, rs2;
		logic [2:0]  f3;
		logic [31:0] a, b, opb, iimm, simm, val, ea, word;
		logic [15:0] ad;
		bit          isr, ok, wr;
		opc  = w[6:0];
		rd   = w[11:7];
		f3   = w[14:12];
		rs1  = w[19:15];
		rs2  = w[24:20];
		f7   = w[31:25];
		a    = gpr[rs1];
		b    = gpr[rs2];
		iimm = {{20{w[31]}}, w[31:20]};
		simm = {{20{w[31]}}, w[31:25], w[11:7]};
		r.rd    = '0;
		r.value = '0;
		r.wr    = 1'b0;
		r.addr  = '0;
		r.st    = ST_OK;
		val     = '0;
		wr      = 1'b0;
		case (opc)
			OP_ALUR, OP_ALUI: begin
				isr = (opc == OP_ALUR);
				if (isr)
					opb = b;
				else if (f3 == F3_SLL || f3 == F3_SR)
					opb = {27'd0, rs2};
				else
					opb = iimm;
				ok = 1'b1;
				case (f3)
					F3_ADD: begin
						if (isr && f7 == F7_ALT)
							val = a - opb;
						else if (isr && f7 != F7_ZERO)
							ok = 1'b0;
						else
							val = a + opb;
					end
					F3_SLL: begin
						if (f7 == F7_ZERO)
							val = a << opb[4:0];
						else
							ok = 1'b0;
					end
					F3_SR: begin
						if (f7 == F7_ZERO)
							val = a >> opb[4:0];
						else if (f7 == F7_ALT)
							val = $signed(a) >>> opb[4:0];
						else
							ok = 1'b0;
					end
					default: begin
						if (isr && f7 != F7_ZERO)
							ok = 1'b0;
						else
							case (f3)
								F3_SLT:  val = {31'd0, $signed(a) < $signed(opb)};
								F3_SLTU: val = {31'd0, a < opb};
								F3_XOR:  val = a ^ opb;
								F3_OR:   val = a | opb;
								default: val = a & opb;
							endcase
					end
				endcase
				if (ok) begin
					wr = 1'b1;
				end else begin
					r.st = ST_UNSUP;
					unsupported++;
				end
			end
			OP_LOAD: begin
				if (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU || f3 == F3_LHU) begin
					ea = a + iimm;
					ad = ea[15:0];
					r.addr = ad;
					wr = 1'b1;
					loads++;
					if ((f3[1:0] == 2'b01 && ad[0]) || (f3 == F3_LW && ad[1:0] != 2'b00)) begin
						r.st = ST_MISALIGN;
						misaligned++;
					end else begin
						word = {dmem[ad + 16'd3], dmem[ad + 16'd2], dmem[ad + 16'd1], dmem[ad]};
						case (f3)
							F3_LB:   val = {{24{word[7]}}, word[7:0]};
							F3_LBU:  val = {24'd0, word[7:0]};
							F3_LH:   val = {{16{word[15]}}, word[15:0]};
							F3_LHU:  val = {16'd0, word[15:0]};
							default: val = word;
						endcase
					end
				end else begin
					r.st = ST_UNSUP;
					unsupported++;
				end
			end
			OP_STORE: begin
				if (f3 <= F3_SW) begin
					ea = a + simm;
					ad = ea[15:0];
					r.addr = ad;
					stores++;
					if ((f3 == F3_SH && ad[0]) || (f3 == F3_SW && ad[1:0] != 2'b00)) begin
						r.st = ST_MISALIGN;
						misaligned++;
					end else begin
						dmem[ad] = b[7:0];
						if (f3 != F3_SB)
							dmem[ad + 16'd1] = b[15:8];
						if (f3 == F3_SW) begin
							dmem[ad + 16'd2] = b[23:16];
							dmem[ad + 16'd3] = b[31:24];
						end
					end
				end else begin
					r.st = ST_UNSUP;
					unsupported++;
				end
			end
			default: begin
				r.st = ST_UNSUP;
				unsupported++;
			end
		endcase
		if (wr)
			r.rd = rd;
		if (wr && rd != 5'd0) begin
			gpr[rd] = val;
			r.wr    = 1'b1;
			r.value = val;
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		retire_t e, p;
		if (!arst_n) begin
			for (int k = 0; k < 32; k++)
				gpr[k] = '0;
			retire_q.delete();
			errors      = 0;
			pending     = 0;
			checked     = 0;
			loads       = 0;
			stores      = 0;
			misaligned  = 0;
			unsupported = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (retire_q.size() == 0) begin
					errors++;
					$display("%0t: result with no instruction pending, expected none, actual rd %0d value %h",
						$time, dest_reg, dest_value);
				end else begin
					e = retire_q.pop_front();
					checked++;
					compare_field("dest_reg", 32'(e.rd), 32'(dest_reg));
					compare_field("dest_value", e.value, dest_value);
					compare_field("dest_written", 32'(e.wr), 32'(dest_written));
					compare_field("access_address", 32'(e.addr), 32'(access_address));
					compare_field("status", 32'(e.st), 32'(status));
				end
			end
			if (instruction_valid && !instruction_stall) begin
				execute(instruction, p);
				retire_q.push_back(p);
			end
			pending = retire_q.size();
		end
	end

endmodule

@@ test/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rvex_pkg::*;

	localparam logic [6:0] OP_LUI     = 7'b0110111;
	localparam logic [6:0] F7_MULDIV  = 7'b0000001;
	localparam logic [2:0] F3_RSVD    = 3'd3;
	localparam int         WATCHDOG   = 3000;
	localparam int         HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        instruction_valid = 1'b0;
	logic        instruction_stall;
	logic [31:0] instruction = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [4:0]  dest_reg;
	logic [31:0] dest_value;
	logic        dest_written;
	logic [15:0] access_address;
	logic [1:0]  status;
	int          errors, pending, checked, loads, stores, misaligned, unsupported;

	typedef struct {
		logic [15:0] addr;
		int          len;
	} span_t;

	int          tx_pct, rx_pct, sent, idle_cycles;
	bit          hold_req, hold_done;
	bit          reg_known [32];
	logic [31:0] reg_val [32];
	span_t       stored[$];

	rv32i_alu_load_store_execute i_dut (.*);

	rv32i_execute_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2, rs1,
			input logic [2:0] f3, input logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OP_ALUR};
	endfunction

	function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
			input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2, rs1,
			input logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
	endfunction

	function automatic logic [4:0] pick_reg();
		logic [4:0] r;
		if ($urandom_range(0, 3) != 0)
			r = 5'($urandom_range(0, 7));
		else
			r = 5'($urandom_range(0, 31));
		return r;
	endfunction

	task automatic send(input logic [31:0] w);
		while ($urandom_range(0, 99) < tx_pct) begin
			instruction_valid <= 1'b0;
			@(posedge clk);
		end
		instruction_valid <= 1'b1;
		instruction       <= w;
		@(posedge clk);
		while (instruction_stall)
			@(posedge clk);
		sent++;
	endtask

	// track base registers and written bytes so loads only touch written memory
	task automatic issue(input logic [31:0] w);
		logic [6:0]  opc;
		logic [4:0]  rd, rs1;
		logic [2:0]  f3;
		logic [31:0] ea, nv;
		logic [15:0] ad;
		int          n;
		bit          nk;
		opc = w[6:0];
		rd  = w[11:7];
		f3  = w[14:12];
		rs1 = w[19:15];
		nk  = 1'b0;
		nv  = '0;
		if (opc == OP_STORE && f3 <= F3_SW && reg_known[rs1]) begin
			ea = reg_val[rs1] + {{20{w[31]}}, w[31:25], w[11:7]};
			ad = ea[15:0];
			n  = (f3 == F3_SB) ? 1 : ((f3 == F3_SH) ? 2 : 4);
			if ((ad % n) == 0) begin
				stored.push_back('{ad, n});
				if (stored.size() > 64)
					void'(stored.pop_front());
			end
		end
		if ((opc == OP_ALUR || opc == OP_ALUI || opc == OP_LOAD) && rd != 5'd0) begin
			if (opc == OP_ALUI && reg_known[rs1]) begin
				if (f3 == F3_ADD) begin
					nk = 1'b1;
					nv = reg_val[rs1] + {{20{w[31]}}, w[31:20]};
				end else if (f3 == F3_SLL && w[31:25] == F7_ZERO) begin
					nk = 1'b1;
					nv = reg_val[rs1] << w[24:20];
				end
			end
			reg_known[rd] = nk;
			reg_val[rd]   = nv;
		end
		send(w);
	endtask

	// find or build a base register that reaches address a with a 12-bit offset
	task automatic aim(input logic [15:0] a, output logic [4:0] base, output logic [11:0] off);
		logic [15:0] d, b16;
		int          s, o;
		bit          hit;
		hit = 1'b0;
		s   = $urandom_range(0, 31);
		if ($urandom_range(0, 2) != 0)
			for (int k = 0; k < 32 && !hit; k++) begin
				base = 5'((s + k) % 32);
				d    = a - reg_val[base][15:0];
				if (reg_known[base] && (d <= 16'h07ff || d >= 16'hf800)) begin
					hit = 1'b1;
					off = d[11:0];
				end
			end
		if (!hit) begin
			base = 5'($urandom_range(1, 31));
			o    = $urandom_range(0, 4080);
			o    = o - 2048;
			b16  = (a - 16'(o)) & 16'hfff0;
			issue(enc_i(b16[15:4], 5'd0, F3_ADD, base, OP_ALUI));
			issue(enc_i({F7_ZERO, 5'd4}, base, F3_SLL, base, OP_ALUI));
			d   = a - b16;
			off = d[11:0];
		end
	endtask

	task automatic mem_store(input logic [15:0] a, input logic [2:0] f3);
		logic [4:0]  base;
		logic [11:0] off;
		aim(a, base, off);
		issue(enc_s(off, pick_reg(), base, f3));
	endtask

	task automatic mem_load(input logic [15:0] a, input logic [2:0] f3);
		logic [4:0]  base;
		logic [11:0] off;
		aim(a, base, off);
		issue(enc_i(off, base, f3, pick_reg(), OP_LOAD));
	endtask

	task automatic load_back();
		span_t      sp;
		int         sz, o;
		logic [2:0] f3;
		if (stored.size() == 0)
			return;
		if ($urandom_range(0, 1) != 0)
			sp = stored[stored.size() - 1];
		else
			sp = stored[$urandom_range(0, stored.size() - 1)];
		sz = 1 << $urandom_range(0, (sp.len == 4) ? 2 : ((sp.len == 2) ? 1 : 0));
		o  = sz * $urandom_range(0, sp.len / sz - 1);
		if (sz == 4)
			f3 = F3_LW;
		else if (sz == 2)
			f3 = $urandom_range(0, 1) ? F3_LH : F3_LHU;
		else
			f3 = $urandom_range(0, 1) ? F3_LB : F3_LBU;
		mem_load(16'(sp.addr + o), f3);
	endtask

	task automatic alu_op();
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [11:0] imm;
		f3 = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 1) != 0) begin
			f7 = ((f3 == F3_ADD || f3 == F3_SR) && $urandom_range(0, 1)) ? F7_ALT : F7_ZERO;
			issue(enc_r(f7, pick_reg(), pick_reg(), f3, pick_reg()));
		end else begin
			imm = 12'($urandom);
			if (f3 == F3_SLL)
				imm[11:5] = F7_ZERO;
			if (f3 == F3_SR)
				imm[11:5] = $urandom_range(0, 1) ? F7_ALT : F7_ZERO;
			issue(enc_i(imm, pick_reg(), f3, pick_reg(), OP_ALUI));
		end
	endtask

	task automatic misalign();
		logic [15:0] a;
		int          k;
		a = 16'($urandom);
		k = $urandom_range(0, 4);
		if (k == 2 || k == 4) begin
			if (a[1:0] == 2'b00)
				a[1:0] = 2'($urandom_range(1, 3));
		end else begin
			a[0] = 1'b1;
		end
		case (k)
			0:       mem_load(a, F3_LH);
			1:       mem_load(a, F3_LHU);
			2:       mem_load(a, F3_LW);
			3:       mem_store(a, F3_SH);
			default: mem_store(a, F3_SW);
		endcase
	endtask

	task automatic noise();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 3))
			0: w[6:0] = OP_ALUR;
			1: w[6:0] = $urandom_range(0, 1) ? OP_ALUI : OP_STORE;
			2: w[6:0] = OP_LOAD;
			default: ;
		endcase
		// loads from an unknown address could hit unwritten bytes
		if (w[6:0] == OP_LOAD && w[14:12] != F3_RSVD && w[14:13] != 2'b11)
			w[14:12] = $urandom_range(0, 1) ? F3_RSVD : {2'b11, w[12]};
		issue(w);
	endtask

	task automatic run_random(input int count);
		logic [15:0] a;
		logic [2:0]  f3;
		int          goal, k;
		goal = sent + count;
		while (sent < goal) begin
			k = $urandom_range(0, 99);
			if (k < 30) begin
				a  = 16'($urandom);
				f3 = 3'($urandom_range(0, 2));
				if (f3 == F3_SH)
					a[0] = 1'b0;
				if (f3 == F3_SW)
					a[1:0] = 2'b00;
				mem_store(a, f3);
				repeat ($urandom_range(0, 2))
					alu_op();
				load_back();
			end else if (k < 45) begin
				load_back();
			end else if (k < 75) begin
				alu_op();
			end else if (k < 85) begin
				misalign();
			end else begin
				noise();
			end
		end
	endtask

	// receiver side, with one long hold to back the pipeline up
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				hold_done = 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < rx_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((instruction_valid && !instruction_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG) begin
			$display("%0t: no item moved for %0d cycles", $time, WATCHDOG);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < 32; k++) begin
			reg_known[k] = 1'b1;
			reg_val[k]   = '0;
		end
		tx_pct = 22;
		rx_pct = 49;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(enc_i(12'hfff, 5'd0, F3_ADD, 5'd1, OP_ALUI));
		issue(enc_i(12'h7ff, 5'd0, F3_ADD, 5'd2, OP_ALUI));
		issue(enc_i({F7_ZERO, 5'd31}, 5'd1, F3_SLL, 5'd3, OP_ALUI));
		issue(enc_i({F7_ALT, 5'd31}, 5'd3, F3_SR, 5'd4, OP_ALUI));
		issue(enc_i({F7_ZERO, 5'd31}, 5'd3, F3_SR, 5'd5, OP_ALUI));
		issue(enc_i(12'hfff, 5'd3, F3_SLT, 5'd6, OP_ALUI));
		issue(enc_i(12'hfff, 5'd2, F3_SLTU, 5'd7, OP_ALUI));
		issue(enc_i(12'h800, 5'd2, F3_XOR, 5'd8, OP_ALUI));
		issue(enc_i(12'h800, 5'd1, F3_AND, 5'd9, OP_ALUI));
		// write to x0 is dropped
		issue(enc_r(F7_ZERO, 5'd2, 5'd1, F3_ADD, 5'd0));
		issue(enc_r(F7_ALT, 5'd2, 5'd3, F3_ADD, 5'd10));
		issue(enc_r(F7_ALT, 5'd1, 5'd3, F3_SR, 5'd11));
		issue(enc_r(F7_ZERO, 5'd2, 5'd3, F3_SLTU, 5'd12));
		issue(enc_s(12'd0, 5'd1, 5'd0, F3_SW));
		issue(enc_s(12'hfff, 5'd2, 5'd0, F3_SB));
		issue(enc_s(12'd4, 5'd3, 5'd0, F3_SH));
		issue(enc_i(12'hfff, 5'd0, F3_LB, 5'd13, OP_LOAD));
		issue(enc_i(12'd2, 5'd0, F3_LHU, 5'd14, OP_LOAD));
		issue(enc_i(12'd0, 5'd0, F3_LW, 5'd15, OP_LOAD));
		issue(enc_i(12'd4, 5'd0, F3_LH, 5'd16, OP_LOAD));
		issue(enc_i(12'd0, 5'd0, F3_LBU, 5'd17, OP_LOAD));
		// misaligned load and store
		issue(enc_i(12'd2, 5'd0, F3_LW, 5'd18, OP_LOAD));
		issue(enc_s(12'd3, 5'd1, 5'd0, F3_SH));
		// unsupported encodings
		issue({20'h12345, 5'd19, OP_LUI});
		issue(enc_i(12'd0, 5'd0, F3_RSVD, 5'd20, OP_LOAD));
		issue(enc_s(12'd0, 5'd1, 5'd0, F3_RSVD));
		issue(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_ADD, 5'd21));
		issue(enc_i({F7_ALT, 5'd3}, 5'd1, F3_SLL, 5'd22, OP_ALUI));

		run_random(210);
		tx_pct = 49;
		rx_pct = 22;
		run_random(210);
		tx_pct   = 0;
		rx_pct   = 0;
		hold_req = 1'b1;
		run_random(210);
		instruction_valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (10)
			@(posedge clk);
		$display("ran %0d instructions: %0d loads, %0d stores, %0d misaligned, %0d unsupported",
			sent, loads, stores, misaligned, unsupported);
		$display("%0d results compared, %0d mismatches", checked, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
